FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on clk, disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ggap_pkg.sv
// ----------------------------------------------------------------------------
// ggap_pkg
// shared types, character codes and helpers of the gga sentence field parser
// ----------------------------------------------------------------------------
package ggap_pkg;

  localparam int ACC_WIDTH = 32;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef logic [ACC_WIDTH-1:0] acc_t;

  typedef enum logic [3:0] {
    PH_HUNT_G1  = 4'd0,
    PH_HUNT_G2  = 4'd1,
    PH_HUNT_A   = 4'd2,
    PH_SKIP     = 4'd3,
    PH_TIME_1ST = 4'd4,
    PH_TIME_INT = 4'd5,
    PH_TIME_FRC = 4'd6,
    PH_LAT_1ST  = 4'd7,
    PH_LAT_INT  = 4'd8,
    PH_LAT_FRC  = 4'd9,
    PH_NS       = 4'd10,
    PH_SEP      = 4'd11,
    PH_LON_1ST  = 4'd12,
    PH_LON_INT  = 4'd13,
    PH_LON_FRC  = 4'd14,
    PH_EW       = 4'd15
  } phase_t;

  typedef struct packed {
    logic emit;
    logic status;
  } emit_t;

  function automatic logic [31:0] to_out32(acc_t acc);
    logic signed [63:0] ext;
    ext = 64'(signed'(acc));
    return ext[31:0];
  endfunction

endpackage

FILE: src/ggap_core.sv
// ----------------------------------------------------------------------------
// ggap_core
// sentence phase tracking and decimal accumulation, one byte per fire
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ggap_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  output ggap_pkg::emit_t   emit_info,
  output ggap_pkg::acc_t    time_next,
  output ggap_pkg::acc_t    lat_next,
  output ggap_pkg::acc_t    lon_next
);

  ggap_pkg::phase_t phase, phase_next;
  ggap_pkg::acc_t   time_accum, lat_accum, lon_accum;
  ggap_pkg::acc_t   time_dig, lat_dig, lon_dig;
  logic             is_comma, is_point;

  function automatic ggap_pkg::acc_t acc_digit(ggap_pkg::acc_t acc, logic [7:0] b);
    return (acc << 3) + (acc << 1) + ggap_pkg::ACC_WIDTH'(b)
           - ggap_pkg::ACC_WIDTH'(ggap_pkg::CH_ZERO);
  endfunction

  assign is_comma = (rx_byte == ggap_pkg::CH_COMMA);
  assign is_point = (rx_byte == ggap_pkg::CH_POINT);
  assign time_dig = acc_digit(time_accum, rx_byte);
  assign lat_dig  = acc_digit(lat_accum, rx_byte);
  assign lon_dig  = acc_digit(lon_accum, rx_byte);

  always_comb begin
    phase_next = phase;
    time_next  = time_accum;
    lat_next   = lat_accum;
    lon_next   = lon_accum;
    emit_info  = '0;
    unique case (phase)
      ggap_pkg::PH_HUNT_G1: begin
        phase_next = (rx_byte == ggap_pkg::CH_G) ? ggap_pkg::PH_HUNT_G2 : ggap_pkg::PH_HUNT_G1;
      end
      ggap_pkg::PH_HUNT_G2: begin
        phase_next = (rx_byte == ggap_pkg::CH_G) ? ggap_pkg::PH_HUNT_A : ggap_pkg::PH_HUNT_G1;
      end
      ggap_pkg::PH_HUNT_A: begin
        phase_next = (rx_byte == ggap_pkg::CH_A) ? ggap_pkg::PH_SKIP : ggap_pkg::PH_HUNT_G1;
      end
      ggap_pkg::PH_SKIP: begin
        if (is_comma) phase_next = ggap_pkg::PH_TIME_1ST;
      end
      ggap_pkg::PH_TIME_1ST: begin
        if (is_comma) begin
          emit_info = '{emit: 1'b1, status: 1'b1};
        end else if (is_point) begin
          phase_next = ggap_pkg::PH_TIME_FRC;
        end else begin
          time_next  = time_dig;
          phase_next = ggap_pkg::PH_TIME_INT;
        end
      end
      ggap_pkg::PH_TIME_INT: begin
        if (is_point) phase_next = ggap_pkg::PH_TIME_FRC;
        else time_next = time_dig;
      end
      ggap_pkg::PH_TIME_FRC: begin
        if (is_comma) phase_next = ggap_pkg::PH_LAT_1ST;
        else time_next = time_dig;
      end
      ggap_pkg::PH_LAT_1ST: begin
        if (is_comma) begin
          emit_info = '{emit: 1'b1, status: 1'b1};
        end else if (is_point) begin
          phase_next = ggap_pkg::PH_LAT_FRC;
        end else begin
          lat_next   = lat_dig;
          phase_next = ggap_pkg::PH_LAT_INT;
        end
      end
      ggap_pkg::PH_LAT_INT: begin
        if (is_point) phase_next = ggap_pkg::PH_LAT_FRC;
        else lat_next = lat_dig;
      end
      ggap_pkg::PH_LAT_FRC: begin
        if (is_comma) phase_next = ggap_pkg::PH_NS;
        else lat_next = lat_dig;
      end
      ggap_pkg::PH_NS: begin
        if (is_comma) begin
          emit_info = '{emit: 1'b1, status: 1'b1};
        end else begin
          if (rx_byte == ggap_pkg::CH_S) lat_next = '0 - lat_accum;
          phase_next = ggap_pkg::PH_SEP;
        end
      end
      ggap_pkg::PH_SEP: begin
        phase_next = ggap_pkg::PH_LON_1ST;
      end
      ggap_pkg::PH_LON_1ST: begin
        if (is_comma) begin
          emit_info = '{emit: 1'b1, status: 1'b1};
        end else if (is_point) begin
          phase_next = ggap_pkg::PH_LON_FRC;
        end else begin
          lon_next   = lon_dig;
          phase_next = ggap_pkg::PH_LON_INT;
        end
      end
      ggap_pkg::PH_LON_INT: begin
        if (is_point) phase_next = ggap_pkg::PH_LON_FRC;
        else lon_next = lon_dig;
      end
      ggap_pkg::PH_LON_FRC: begin
        if (is_comma) phase_next = ggap_pkg::PH_EW;
        else lon_next = lon_dig;
      end
      ggap_pkg::PH_EW: begin
        if (is_comma) begin
          emit_info = '{emit: 1'b1, status: 1'b1};
        end else begin
          if (rx_byte == ggap_pkg::CH_W) lon_next = '0 - lon_accum;
          emit_info = '{emit: 1'b1, status: 1'b0};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ggap_pkg::PH_HUNT_G1;
      time_accum <= '0;
      lat_accum  <= '0;
      lon_accum  <= '0;
    end else if (fire) begin
      if (emit_info.emit) begin
        phase      <= ggap_pkg::PH_HUNT_G1;
        time_accum <= '0;
        lat_accum  <= '0;
        lon_accum  <= '0;
      end else begin
        phase      <= phase_next;
        time_accum <= time_next;
        lat_accum  <= lat_next;
        lon_accum  <= lon_next;
      end
    end
  end

  // a result always ends the sentence and clears the accumulators
  `ASSERT_NEXT(a_emit_clears, fire && emit_info.emit,
    phase == ggap_pkg::PH_HUNT_G1 && time_accum == '0 && lat_accum == '0 && lon_accum == '0,
    "accumulators not cleared after result")
  // only the field phases may end a sentence
  `ASSERT_IMPL(a_emit_phase, emit_info.emit,
    phase == ggap_pkg::PH_TIME_1ST || phase == ggap_pkg::PH_LAT_1ST ||
    phase == ggap_pkg::PH_NS || phase == ggap_pkg::PH_LON_1ST || phase == ggap_pkg::PH_EW,
    "result raised outside a field phase")
  // the phase only moves on a fired byte
  `ASSERT_NEXT(a_hold_phase, !fire, $stable(phase),
    "phase moved without a fired byte")

endmodule

FILE: src/gga_sentence_field_parser.sv
// result: a result beat is loaded into the result register at the edge at which its
//   last byte leaves the input register
// throughput: one byte per cycle, limited only by the output register being held
// reset: synchronous rst returns to hunting for the first G, clears the accumulators
//   and the input and result valid flags
// ----------------------------------------------------------------------------
// gga_sentence_field_parser
// gga sentence parser: extracts time, latitude and longitude from a byte stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gga_sentence_field_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] utc_time,
  output logic signed [31:0] lat_value,
  output logic signed [31:0] lon_value,
  output logic               parse_status
);

  logic            byte_valid;
  logic [7:0]      byte_q;
  logic            fire;
  logic            out_busy;
  ggap_pkg::emit_t emit_info;
  ggap_pkg::acc_t  time_next, lat_next, lon_next;

  assign out_busy = out_valid && out_stall;
  assign fire     = byte_valid && !(emit_info.emit && out_busy);
  assign in_stall = byte_valid && !fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= rx_byte;
    end
  end

  ggap_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (byte_q),
    .emit_info (emit_info),
    .time_next (time_next),
    .lat_next  (lat_next),
    .lon_next  (lon_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit_info.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit_info.emit) begin
      utc_time     <= signed'(ggap_pkg::to_out32(time_next));
      lat_value    <= signed'(ggap_pkg::to_out32(lat_next));
      lon_value    <= signed'(ggap_pkg::to_out32(lon_next));
      parse_status <= emit_info.status;
    end
  end

  // a held result beat is never overwritten
  `ASSERT_IMPL(a_no_overwrite, out_busy, !(fire && emit_info.emit),
    "result register overwritten while held")
  // the input side only stalls on a pending byte
  `ASSERT_IMPL(a_stall_pending, in_stall, byte_valid && emit_info.emit && out_busy,
    "input stalled without a blocked result")
  // a new result beat appears only from a fired byte
  `ASSERT_NEXT(a_result_source, !out_valid && !(fire && emit_info.emit), !out_valid,
    "result beat without a fired byte")

endmodule
